// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit block allocator: the per-block
// status codes, the result codes and the request opcodes.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // Status of one block in the table
  typedef enum logic [2:0] {
    ENT_FREE   = 3'd0,
    ENT_SINGLE = 3'd1,
    ENT_FIRST  = 3'd2,
    ENT_CONT   = 3'd3,
    ENT_LAST   = 3'd4
  } blk_state_t;

  // Result codes returned with each transaction
  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_ZERO    = 2'd1,
    RES_NOFIT   = 2'd2,
    RES_IGNORED = 2'd3
  } res_code_t;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

// ===== rtl/ffba_cell.sv =====
// ----------------------------------------------------------------------------
// ffba_cell
// One status entry of the block table. While the ring rotates, the entry
// takes the value of its neighbor; otherwise it holds.
// ----------------------------------------------------------------------------
module ffba_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   shift_en,
  input  ffba_pkg::blk_state_t   d,
  output ffba_pkg::blk_state_t   q
);
  import ffba_pkg::*;

  blk_state_t state_r;

  // Clear to free at reset, advance on shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENT_FREE;
    end else if (shift_en) begin
      state_r <= d;
    end
  end

  assign q = state_r;

endmodule

// ===== rtl/first_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit contiguous block allocator over a table of NUM_BLOCKS entries.
// Requests enter on the in_ channel (valid/ready); each one returns exactly
// one result transaction on the out_ channel (valid/ready). Opcode 0
// allocates the lowest-starting run of request_size free blocks, opcode 1
// frees the run that starts at free_index.
// The table is a ring of NUM_BLOCKS cells that rotates by one entry per
// cycle during the search, marking and free passes, past a single
// read/modify point. An allocate that fits runs a search pass and then a
// marking pass; an allocate with no fit runs the search pass alone; a free
// of a valid index runs one free pass; a zero size or a bad index runs no
// pass. One request is in work at a time; in_ready is high only while
// idle, so the next request is taken only after the current one has moved
// its result into the output register. The result sits in that register;
// while the receiver stalls, the next request can still be accepted and
// run, and its result waits until the register empties. Reset
// (synchronous, active low) clears every entry to free and drops out_valid.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [4:0] in_request_size,
  input  logic [3:0] in_free_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_code,
  output logic [3:0] out_start_index
);
  import ffba_pkg::*;

  localparam int CW = $clog2(NUM_BLOCKS);
  localparam int LW = ($clog2(NUM_BLOCKS + 1) > 5) ? $clog2(NUM_BLOCKS + 1) : 5;
  localparam int IW = (CW > 4) ? CW : 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_DONE
  } fsm_t;

  fsm_t            state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic            found_r, found_nxt;
  logic            walk_r, walk_nxt;
  logic [CW-1:0]   start_r, start_nxt;
  logic [CW-1:0]   end_r, end_nxt;
  logic            op_r, op_nxt;
  logic [4:0]      size_r, size_nxt;
  logic [3:0]      idx_r, idx_nxt;
  res_code_t       code_r, code_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_code_r, out_code_nxt;
  logic [3:0]      out_start_r, out_start_nxt;

  blk_state_t      cell_q [NUM_BLOCKS];
  blk_state_t      head;
  blk_state_t      wr_val;
  logic            shift_en;
  logic            last_cnt;
  logic [LW-1:0]   len_inc;

  // Ring of status cells; the tail takes the value written at the head
  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    blk_state_t cell_d;
    if (i == NUM_BLOCKS - 1) begin : g_tail
      assign cell_d = wr_val;
    end else begin : g_body
      assign cell_d = cell_q[i+1];
    end
    ffba_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (cell_d),
      .q        (cell_q[i])
    );
  end

  assign head     = cell_q[0];
  assign shift_en = (state_r == S_SCAN) || (state_r == S_MARK) || (state_r == S_FREE);
  assign last_cnt = (cnt_r == CW'(NUM_BLOCKS - 1));
  assign len_inc  = len_r + LW'(1);
  assign in_ready = (state_r == S_IDLE);

  // Next-state and datapath decisions
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    found_nxt     = found_r;
    walk_nxt      = walk_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    op_nxt        = op_r;
    size_nxt      = size_r;
    idx_nxt       = idx_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_start_nxt = out_start_r;
    wr_val        = head;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        cnt_nxt   = '0;
        len_nxt   = '0;
        found_nxt = 1'b0;
        walk_nxt  = 1'b0;
        if (in_valid) begin
          op_nxt   = in_opcode;
          size_nxt = in_request_size;
          idx_nxt  = in_free_index;
          if (in_opcode == OP_ALLOC) begin
            if (in_request_size == 5'd0) begin
              code_nxt  = RES_ZERO;
              state_nxt = S_DONE;
            end else begin
              code_nxt  = RES_NOFIT;
              state_nxt = S_SCAN;
            end
          end else begin
            code_nxt = RES_IGNORED;
            if (32'(in_free_index) >= NUM_BLOCKS) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_FREE;
            end
          end
        end
      end

      S_SCAN: begin
        // Track the current free run and latch the first that fits
        if (head != ENT_FREE) begin
          len_nxt = '0;
        end else if (!found_r) begin
          len_nxt = len_inc;
          if (len_inc == LW'(size_r)) begin
            found_nxt = 1'b1;
            start_nxt = cnt_r - CW'(len_r);
            end_nxt   = cnt_r;
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (last_cnt) begin
          cnt_nxt = '0;
          if (found_nxt) begin
            state_nxt = S_MARK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_MARK: begin
        // Rewrite the entries of the chosen run
        if ((cnt_r >= start_r) && (cnt_r <= end_r)) begin
          if (start_r == end_r) begin
            wr_val = ENT_SINGLE;
          end else if (cnt_r == start_r) begin
            wr_val = ENT_FIRST;
          end else if (cnt_r == end_r) begin
            wr_val = ENT_LAST;
          end else begin
            wr_val = ENT_CONT;
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (last_cnt) begin
          cnt_nxt   = '0;
          code_nxt  = RES_OK;
          state_nxt = S_DONE;
        end
      end

      S_FREE: begin
        // Free the run head, then walk its continuation entries
        if (IW'(cnt_r) == IW'(idx_r)) begin
          if (head == ENT_SINGLE) begin
            wr_val   = ENT_FREE;
            code_nxt = RES_OK;
          end else if (head == ENT_FIRST) begin
            wr_val   = ENT_FREE;
            code_nxt = RES_OK;
            walk_nxt = 1'b1;
          end
        end else if (walk_r) begin
          if (head == ENT_CONT) begin
            wr_val = ENT_FREE;
          end else if (head == ENT_LAST) begin
            wr_val   = ENT_FREE;
            walk_nxt = 1'b0;
          end else begin
            walk_nxt = 1'b0;
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (last_cnt) begin
          cnt_nxt   = '0;
          walk_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = code_r;
          if (code_r == RES_OK && op_r == OP_ALLOC) begin
            out_start_nxt = 4'(start_r);
          end else begin
            out_start_nxt = 4'd0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, request and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      len_r       <= '0;
      found_r     <= 1'b0;
      walk_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      found_r     <= found_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    op_r        <= op_nxt;
    size_r      <= size_nxt;
    idx_r       <= idx_nxt;
    code_r      <= code_nxt;
    out_code_r  <= out_code_nxt;
    out_start_r <= out_start_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_code = out_code_r;
  assign out_start_index = out_start_r;

`ifndef SYNTHESIS
  // Reset leaves the head entry free
  a_reset_free: assert property (@(posedge clk) !rst_n |=> (cell_q[0] == ENT_FREE))
    else $error("head entry not free after reset");

  // The marking pass runs only for a run that was found
  a_mark_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> found_r)
    else $error("marking pass without a found run");

  // Every rotation ends realigned at entry zero
  a_realign: assert property (@(posedge clk) disable iff (!rst_n)
    (shift_en && last_cnt) |=> (cnt_r == '0))
    else $error("ring not realigned after a full pass");

  // No free walk outlives its pass
  a_walk_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !walk_r)
    else $error("free walk active outside the free pass");

  // A result is not overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_code_r)
      && $stable(out_start_r)))
    else $error("pending result changed");
`endif

endmodule
